/* hw/rtl/qni_pkg.sv */
// Shared types and codes for the quaternion normalize / inverse core.
// No dependencies.
package qni_pkg;

   localparam logic [1:0] MODE_NORMALIZE = 2'd0;
   localparam logic [1:0] MODE_CONJUGATE = 2'd1;
   localparam logic [1:0] MODE_INVERSE   = 2'd2;
   localparam logic [1:0] MODE_MAGNITUDE = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   // control that travels beside the data through the pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
   } ctrl_type;

endpackage

/* hw/rtl/qni_square.sv */
// One lane of the front stage: split a signed component into sign and magnitude
// and square the magnitude. Depends on nothing.
module qni_square #(
   parameter int W = 16
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [W-1:0]      comp,
   output logic              neg_ff,
   output logic [W-1:0]      mag_ff,
   output logic [2*W-1:0]    sq_ff
);

   logic [W-1:0] mag_in;

   // the most negative value negates to 2^(W-1) as an unsigned magnitude
   assign mag_in = comp[W-1] ? (~comp + {{(W-1){1'b0}}, 1'b1}) : comp;

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= comp[W-1];
         mag_ff <= mag_in;
         sq_ff  <= (2*W)'(mag_in) * (2*W)'(mag_in);
      end
   end

endmodule

/* hw/rtl/qni_sqrt_step.sv */
// One step of the digit-by-digit square root: two radicand bits in, one root bit out.
// Depends on qni_pkg.
module qni_sqrt_step #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  qni_pkg::ctrl_type   ctl_in,
   input  logic [W+4:0]        rem_in,
   input  logic [W:0]          root_in,
   input  logic [1:0]          pair,
   output qni_pkg::ctrl_type   ctl_ff,
   output logic [W+4:0]        rem_ff,
   output logic [W:0]          root_ff
);

   localparam int RW  = W + 1;
   localparam int RMW = W + 5;

   logic [RMW-1:0] cur;
   logic [RMW-1:0] trial;
   logic           take;

   assign cur   = {rem_in[RMW-3:0], pair};
   assign trial = {RMW'(root_in) << 2} | RMW'(1);
   assign take  = (cur >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff.mode <= ctl_in.mode;
         rem_ff      <= take ? (cur - trial) : cur;
         root_ff     <= {root_in[RW-2:0], take};
      end
   end

endmodule

/* hw/rtl/qni_div_step.sv */
// One step of a restoring divider lane: one numerator bit in, one quotient bit out,
// with a sticky flag once the quotient passes the saturation cap. Depends on nothing.
module qni_div_step #(
   parameter int W  = 16,
   parameter int DW = 33
) (
   input  logic            clock,
   input  logic            adv,
   input  logic [DW-1:0]   r_in,
   input  logic [W+1:0]    q_in,
   input  logic            big_in,
   input  logic            num_bit,
   input  logic [DW-1:0]   d,
   output logic [DW-1:0]   r_ff,
   output logic [W+1:0]    q_ff,
   output logic            big_ff
);

   localparam int QW = W + 2;
   localparam logic [QW:0] CAP = {2'b00, 1'b1, {W{1'b0}}};

   logic [DW:0]   t;
   logic [DW:0]   diff;
   logic          qb;
   logic [QW:0]   qn;

   assign t    = {r_in, num_bit};
   assign qb   = (t >= {1'b0, d});
   assign diff = t - {1'b0, d};
   assign qn   = {q_in, qb};

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff   <= qb ? diff[DW-1:0] : t[DW-1:0];
         q_ff   <= qn[QW-1:0];
         big_ff <= big_in | (qn > CAP);
      end
   end

endmodule

/* hw/rtl/quaternion_normalize_inverse_core.sv */
// Top level of the quaternion normalize / conjugate / inverse / magnitude core.
// Depends on qni_pkg, qni_square, qni_sqrt_step and qni_div_step.
//
// Usage:
//   One quaternion (req_qx, req_qy, req_qz, req_qw, signed fixed point with
//   FRACTION_BITS fraction bits) and a req_mode transfer in when req_valid is
//   high and req_stall is low. Each transfer in yields exactly one transfer out
//   on the rsp_ channel, in order: rsp_rx..rsp_rw, rsp_magnitude and rsp_status.
//   Throughput: one transfer per cycle unless rsp_stall holds the pipeline. The
//   square root yields one root bit per stage, and the divider lanes yield one
//   quotient bit per stage over COMPONENT_WIDTH + 2*FRACTION_BITS stages.
//   Normalize divides by the magnitude scaled up by 2^FRACTION_BITS, so both
//   divisions share the same divider lanes.
//   Reset clears every valid bit; the pipeline comes up empty and needs no
//   warm-up. When the receiver holds rsp_stall with a result waiting, the
//   whole pipeline holds, bubbles included, and req_stall rises; every stage
//   keeps its item, so nothing is lost or repeated.
module quaternion_normalize_inverse_core #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic signed [COMPONENT_WIDTH-1:0] req_qx,
   input  logic signed [COMPONENT_WIDTH-1:0] req_qy,
   input  logic signed [COMPONENT_WIDTH-1:0] req_qz,
   input  logic signed [COMPONENT_WIDTH-1:0] req_qw,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rx,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_ry,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rz,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rw,
   output logic [COMPONENT_WIDTH:0]          rsp_magnitude,
   output logic [1:0]                        rsp_status
);

   localparam int W         = COMPONENT_WIDTH;
   localparam int F         = FRACTION_BITS;
   localparam int SW        = 2*W + 1;              // sum of squares
   localparam int SQ_STEPS  = W + 1;                // root bits
   localparam int RW        = W + 1;
   localparam int RMW       = W + 5;
   localparam int DW        = (W + 1 + F > 2*W + 1) ? (W + 1 + F) : (2*W + 1);
   localparam int QW        = W + 2;
   localparam int DIV_STEPS = W + 2*F;

   localparam logic [QW:0] POS_LIM = {4'b0000, {(W-1){1'b1}}};
   localparam logic [QW:0] NEG_LIM = {3'b000, 1'b1, {(W-1){1'b0}}};
   localparam logic [QW:0] CAP     = {2'b00, 1'b1, {W{1'b0}}};

   // advance the whole pipeline unless a finished result is held
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------- square
   logic [W-1:0]   comp_in [0:3];
   logic [3:0]     neg_a;
   logic [W-1:0]   mag_a   [0:3];
   logic [2*W-1:0] sq_a    [0:3];
   qni_pkg::ctrl_type ctl_a_ff;

   assign comp_in[0] = req_qx;
   assign comp_in[1] = req_qy;
   assign comp_in[2] = req_qz;
   assign comp_in[3] = req_qw;

   for (genvar l = 0; l < 4; l++) begin : g_square
      qni_square #(.W(W)) u_square (
         .clock  (clock),
         .adv    (adv),
         .comp   (comp_in[l]),
         .neg_ff (neg_a[l]),
         .mag_ff (mag_a[l]),
         .sq_ff  (sq_a[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_a_ff.valid <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_a_ff.mode <= req_mode;
      end
   end

   // ---------------------------------------------------------------- sum
   qni_pkg::ctrl_type ctl_b_ff;
   logic [3:0]        neg_b_ff;
   logic [4*W-1:0]    mag_b_ff;
   logic [SW-1:0]     sum_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_b_ff.valid <= ctl_a_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_b_ff.mode <= ctl_a_ff.mode;
         neg_b_ff      <= neg_a;
         mag_b_ff      <= {mag_a[3], mag_a[2], mag_a[1], mag_a[0]};
         sum_b_ff      <= SW'(sq_a[0]) + SW'(sq_a[1]) + SW'(sq_a[2]) + SW'(sq_a[3]);
      end
   end

   // ---------------------------------------------------------------- square root
   qni_pkg::ctrl_type sq_ctl  [0:SQ_STEPS];
   logic [RMW-1:0]    sq_rem  [0:SQ_STEPS];
   logic [RW-1:0]     sq_root [0:SQ_STEPS];
   logic [3:0]        sq_neg  [0:SQ_STEPS];
   logic [4*W-1:0]    sq_mag  [0:SQ_STEPS];
   logic [SW-1:0]     sq_sum  [0:SQ_STEPS];

   logic [3:0]        sq_neg_ff [1:SQ_STEPS];
   logic [4*W-1:0]    sq_mag_ff [1:SQ_STEPS];
   logic [SW-1:0]     sq_sum_ff [1:SQ_STEPS];

   assign sq_ctl[0]  = ctl_b_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_neg[0]  = neg_b_ff;
   assign sq_mag[0]  = mag_b_ff;
   assign sq_sum[0]  = sum_b_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [2*SQ_STEPS-1:0] padded;

      // pad the radicand to an even bit count, take pairs from the top
      assign padded = (2*SQ_STEPS)'(sq_sum[k]);

      qni_sqrt_step #(.W(W)) u_step (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl_in  (sq_ctl[k]),
         .rem_in  (sq_rem[k]),
         .root_in (sq_root[k]),
         .pair    (padded[2*(SQ_STEPS-1-k) +: 2]),
         .ctl_ff  (sq_ctl[k+1]),
         .rem_ff  (sq_rem[k+1]),
         .root_ff (sq_root[k+1])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_neg_ff[k+1] <= sq_neg[k];
            sq_mag_ff[k+1] <= sq_mag[k];
            sq_sum_ff[k+1] <= sq_sum[k];
         end
      end

      assign sq_neg[k+1] = sq_neg_ff[k+1];
      assign sq_mag[k+1] = sq_mag_ff[k+1];
      assign sq_sum[k+1] = sq_sum_ff[k+1];
   end

   // ---------------------------------------------------------------- round root, pick divisor
   qni_pkg::ctrl_type ctl_c_ff;
   logic [3:0]        neg_c_ff;
   logic [4*W-1:0]    mag_c_ff;
   logic              zero_c_ff;
   logic [RW-1:0]     m_c_ff;
   logic [DW-1:0]     d_c_ff;
   logic [RW-1:0]     m_in;

   // round to nearest: bump the root when the remainder exceeds it
   assign m_in = sq_root[SQ_STEPS]
               + RW'(sq_rem[SQ_STEPS] > RMW'(sq_root[SQ_STEPS]));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_c_ff.valid <= sq_ctl[SQ_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_c_ff.mode <= sq_ctl[SQ_STEPS].mode;
         neg_c_ff      <= sq_neg[SQ_STEPS];
         mag_c_ff      <= sq_mag[SQ_STEPS];
         zero_c_ff     <= (sq_sum[SQ_STEPS] == '0);
         m_c_ff        <= m_in;
         // normalize: a*2^F/M equals a*2^(2F)/(M*2^F)
         d_c_ff        <= (sq_ctl[SQ_STEPS].mode == qni_pkg::MODE_NORMALIZE)
                          ? (DW'(m_in) << F) : DW'(sq_sum[SQ_STEPS]);
      end
   end

   // ---------------------------------------------------------------- divider lanes
   qni_pkg::ctrl_type dv_ctl  [0:DIV_STEPS];
   logic [3:0]        dv_neg  [0:DIV_STEPS];
   logic [4*W-1:0]    dv_mag  [0:DIV_STEPS];
   logic              dv_zero [0:DIV_STEPS];
   logic [RW-1:0]     dv_m    [0:DIV_STEPS];
   logic [DW-1:0]     dv_d    [0:DIV_STEPS];
   logic [DW-1:0]     dv_r    [0:DIV_STEPS][0:3];
   logic [QW-1:0]     dv_q    [0:DIV_STEPS][0:3];
   logic              dv_big  [0:DIV_STEPS][0:3];

   qni_pkg::ctrl_type dv_ctl_ff  [1:DIV_STEPS];
   logic [3:0]        dv_neg_ff  [1:DIV_STEPS];
   logic [4*W-1:0]    dv_mag_ff  [1:DIV_STEPS];
   logic              dv_zero_ff [1:DIV_STEPS];
   logic [RW-1:0]     dv_m_ff    [1:DIV_STEPS];
   logic [DW-1:0]     dv_d_ff    [1:DIV_STEPS];

   assign dv_ctl[0]  = ctl_c_ff;
   assign dv_neg[0]  = neg_c_ff;
   assign dv_mag[0]  = mag_c_ff;
   assign dv_zero[0] = zero_c_ff;
   assign dv_m[0]    = m_c_ff;
   assign dv_d[0]    = d_c_ff;

   for (genvar l = 0; l < 4; l++) begin : g_div_init
      assign dv_r[0][l]   = '0;
      assign dv_q[0][l]   = '0;
      assign dv_big[0][l] = 1'b0;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic nb;

         // numerator is the magnitude followed by 2F zero bits
         if (k < W) begin : g_mag_bit
            assign nb = dv_mag[k][l*W + (W-1-k)];
         end else begin : g_zero_bit
            assign nb = 1'b0;
         end

         qni_div_step #(.W(W), .DW(DW)) u_step (
            .clock   (clock),
            .adv     (adv),
            .r_in    (dv_r[k][l]),
            .q_in    (dv_q[k][l]),
            .big_in  (dv_big[k][l]),
            .num_bit (nb),
            .d       (dv_d[k]),
            .r_ff    (dv_r[k+1][l]),
            .q_ff    (dv_q[k+1][l]),
            .big_ff  (dv_big[k+1][l])
         );
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            dv_ctl_ff[k+1].valid <= dv_ctl[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctl_ff[k+1].mode <= dv_ctl[k].mode;
            dv_neg_ff[k+1]      <= dv_neg[k];
            dv_mag_ff[k+1]      <= dv_mag[k];
            dv_zero_ff[k+1]     <= dv_zero[k];
            dv_m_ff[k+1]        <= dv_m[k];
            dv_d_ff[k+1]        <= dv_d[k];
         end
      end

      assign dv_ctl[k+1]  = dv_ctl_ff[k+1];
      assign dv_neg[k+1]  = dv_neg_ff[k+1];
      assign dv_mag[k+1]  = dv_mag_ff[k+1];
      assign dv_zero[k+1] = dv_zero_ff[k+1];
      assign dv_m[k+1]    = dv_m_ff[k+1];
      assign dv_d[k+1]    = dv_d_ff[k+1];
   end

   // ---------------------------------------------------------------- round, saturate, select
   logic [W-1:0] res_in [0:3];
   logic [1:0]   status_in;

   always_comb begin
      logic [1:0]    mode;
      logic          zero;
      logic          sat_any;
      logic          inc;
      logic [QW:0]   qf;
      logic [QW:0]   val;
      logic          over;
      logic          sgn;
      logic [QW:0]   lim;

      mode    = dv_ctl[DIV_STEPS].mode;
      zero    = dv_zero[DIV_STEPS];
      sat_any = 1'b0;

      for (int l = 0; l < 4; l++) begin
         // final rounding bit: twice the remainder against the divisor
         inc = ({dv_r[DIV_STEPS][l], 1'b0} >= {1'b0, dv_d[DIV_STEPS]});
         qf  = (QW+1)'(dv_q[DIV_STEPS][l]) + (QW+1)'(inc);

         if (mode == qni_pkg::MODE_CONJUGATE) begin
            val  = (QW+1)'(dv_mag[DIV_STEPS][l*W +: W]);
            over = 1'b0;
         end else begin
            val  = qf;
            over = dv_big[DIV_STEPS][l] || (qf > CAP);
         end

         // conjugate and inverse flip the imaginary signs
         if (mode == qni_pkg::MODE_NORMALIZE || l == 3) begin
            sgn = dv_neg[DIV_STEPS][l];
         end else begin
            sgn = !dv_neg[DIV_STEPS][l];
         end

         lim = sgn ? NEG_LIM : POS_LIM;
         if (over || val > lim) begin
            val = lim;
            if (mode != qni_pkg::MODE_MAGNITUDE && !zero) begin
               sat_any = 1'b1;
            end
            if (mode == qni_pkg::MODE_CONJUGATE) begin
               sat_any = 1'b1;
            end
         end

         if (mode == qni_pkg::MODE_MAGNITUDE) begin
            res_in[l] = '0;
         end else if (zero && mode != qni_pkg::MODE_CONJUGATE) begin
            // zero norm: passthrough of an all-zero input, or the zeroed inverse
            res_in[l] = '0;
         end else begin
            res_in[l] = sgn ? (~val[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : val[W-1:0];
         end
      end

      if (zero && (mode == qni_pkg::MODE_NORMALIZE || mode == qni_pkg::MODE_INVERSE)) begin
         status_in = qni_pkg::STATUS_ZERO;
      end else if (sat_any) begin
         status_in = qni_pkg::STATUS_SAT;
      end else begin
         status_in = qni_pkg::STATUS_OK;
      end
   end

   // ---------------------------------------------------------------- output register
   logic [W-1:0] rx_ff, ry_ff, rz_ff, rw_ff;
   logic [RW-1:0] magnitude_ff;
   logic [1:0]    status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ctl[DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff        <= res_in[0];
         ry_ff        <= res_in[1];
         rz_ff        <= res_in[2];
         rw_ff        <= res_in[3];
         magnitude_ff <= dv_m[DIV_STEPS];
         status_ff    <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rx        = rx_ff;
   assign rsp_ry        = ry_ff;
   assign rsp_rz        = rz_ff;
   assign rsp_rw        = rw_ff;
   assign rsp_magnitude = magnitude_ff;
   assign rsp_status    = status_ff;

   // ---------------------------------------------------------------- assertions
   // the pipeline comes out of reset empty
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a zero-norm flag comes with all-zero components and magnitude
   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == qni_pkg::STATUS_ZERO) |->
      (rsp_rx == '0 && rsp_ry == '0 && rsp_rz == '0 && rsp_rw == '0 &&
       rsp_magnitude == '0))
      else $error("zero-norm result with nonzero fields");

   // a zero magnitude means an all-zero input, which cannot saturate
   a_zero_no_sat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_magnitude == '0) |-> (rsp_status != qni_pkg::STATUS_SAT))
      else $error("saturation flagged on a zero input");

endmodule

/* sim/tb_quaternion_normalize_inverse_core.sv */
// Self-checking testbench for quaternion_normalize_inverse_core: random and directed
// quaternions in all four modes, with an in-bench fixed-point predictor of every result.
// Depends on qni_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_quaternion_normalize_inverse_core;

   localparam int CW = 16;
   localparam int FB = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [1:0]          mode;
      logic [CW-1:0]       q[4];
      bit                  wait_drain;   // hold off until every result is back
   } quat_req_type;

   typedef struct {
      logic [CW-1:0]       r[4];
      logic [CW:0]         magnitude;
      logic [1:0]          status;
   } quat_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic signed [CW-1:0] req_qx = '0, req_qy = '0, req_qz = '0, req_qw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_rx, rsp_ry, rsp_rz, rsp_rw;
   logic [CW:0] rsp_magnitude;
   logic [1:0] rsp_status;

   quat_req_type pending_quats[$];
   quat_rsp_type expected_results[$];
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        error_count = 0;
   int        quiet_cycles = 0;
   bit        req_taken = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   quaternion_normalize_inverse_core i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_mode,
      .req_qx, .req_qy, .req_qz, .req_qw,
      .rsp_valid, .rsp_stall, .rsp_rx, .rsp_ry, .rsp_rz, .rsp_rw,
      .rsp_magnitude, .rsp_status
   );

   // Clamp a sign and magnitude to the signed component range; flag saturation.
   function automatic logic [CW-1:0] clamp_component(bit neg, longint unsigned m,
                                                     ref bit sat);
      if (!neg) begin
         if (m > (64'd1 << (CW-1)) - 1) begin
            sat = 1'b1;
            m = (64'd1 << (CW-1)) - 1;
         end
         return m[CW-1:0];
      end
      if (m > (64'd1 << (CW-1))) begin
         sat = 1'b1;
         m = 64'd1 << (CW-1);
      end
      return CW'(-m);
   endfunction

   // Expected result of one quaternion transfer.
   function automatic quat_rsp_type quat_result(quat_req_type t);
      quat_rsp_type res;
      bit neg[4];
      longint unsigned mg[4];
      longint unsigned sum, root, m, q;
      bit sat;
      sum = 0;
      sat = 1'b0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = t.q[i][CW-1];
         mg[i] = neg[i] ? (64'd1 << CW) - t.q[i] : 64'(t.q[i]);
         sum += mg[i] * mg[i];
         res.r[i] = '0;
      end
      // floor root, then round to nearest
      root = 0;
      for (int b = 20; b >= 0; b--)
         if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= sum) root |= 64'd1 << b;
      m = (sum - root * root > root) ? root + 1 : root;
      res.status = qni_pkg::STATUS_OK;
      case (t.mode)
         qni_pkg::MODE_NORMALIZE: begin
            if (sum == 0) begin
               res.status = qni_pkg::STATUS_ZERO;
               res.r = t.q;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  q = ((mg[i] << (FB+1)) + m) / (2 * m);
                  res.r[i] = clamp_component(neg[i], q, sat);
               end
            end
         end
         qni_pkg::MODE_CONJUGATE: begin
            for (int i = 0; i < 4; i++)
               res.r[i] = clamp_component(i < 3 ? !neg[i] : neg[i], mg[i], sat);
         end
         qni_pkg::MODE_INVERSE: begin
            if (sum == 0) res.status = qni_pkg::STATUS_ZERO;
            else begin
               for (int i = 0; i < 4; i++) begin
                  q = ((mg[i] << (2*FB+1)) + sum) / (2 * sum);
                  res.r[i] = clamp_component(i < 3 ? !neg[i] : neg[i], q, sat);
               end
            end
         end
         default: ;
      endcase
      if (res.status == qni_pkg::STATUS_OK && sat) res.status = qni_pkg::STATUS_SAT;
      res.magnitude = m[CW:0];
      return res;
   endfunction

   // Record accepted requests and check accepted results at the rising edge.
   always @(posedge clock) begin
      quat_req_type t;
      quat_rsp_type e;
      bit moved;
      bit took;
      moved = 1'b0;
      took = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         t.mode = req_mode;
         t.q[0] = req_qx;
         t.q[1] = req_qy;
         t.q[2] = req_qz;
         t.q[3] = req_qw;
         t.wait_drain = 1'b0;
         expected_results.push_back(quat_result(t));
         took = 1'b1;
         moved = 1'b1;
      end
      req_taken <= took;
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_rx !== e.r[0]) begin
               $error("rx: expected %0d, got %0d", $signed(e.r[0]), rsp_rx);
               error_count++;
            end
            if (rsp_ry !== e.r[1]) begin
               $error("ry: expected %0d, got %0d", $signed(e.r[1]), rsp_ry);
               error_count++;
            end
            if (rsp_rz !== e.r[2]) begin
               $error("rz: expected %0d, got %0d", $signed(e.r[2]), rsp_rz);
               error_count++;
            end
            if (rsp_rw !== e.r[3]) begin
               $error("rw: expected %0d, got %0d", $signed(e.r[3]), rsp_rw);
               error_count++;
            end
            if (rsp_magnitude !== e.magnitude) begin
               $error("magnitude: expected %0d, got %0d", e.magnitude, rsp_magnitude);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               error_count++;
            end
         end
      end
      // watchdog: count cycles in which nothing transfers
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Driver: advance to the next item once the current one transferred; hold while stalled.
   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || req_taken) begin
            if (pending_quats.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_quats[0].wait_drain && expected_results.size() != 0)) begin
               quat_req_type t;
               t = pending_quats.pop_front();
               req_mode <= t.mode;
               req_qx <= t.q[0];
               req_qy <= t.q[1];
               req_qz <= t.q[2];
               req_qw <= t.q[3];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic add_quat(logic [1:0] mode, logic [CW-1:0] x, logic [CW-1:0] y,
                           logic [CW-1:0] z, logic [CW-1:0] w, bit wait_drain = 1'b0);
      quat_req_type t;
      t.mode = mode;
      t.q[0] = x;
      t.q[1] = y;
      t.q[2] = z;
      t.q[3] = w;
      t.wait_drain = wait_drain;
      pending_quats.push_back(t);
   endtask

   // Random component: full range, small values near unit scale, the two extremes, or zero.
   function automatic logic [CW-1:0] random_component();
      case ($urandom_range(9))
         0:       return '0;
         1, 2, 3: return CW'($signed($urandom_range(8192)) - 4096);
         4:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_quats.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      logic [1:0] modes[4];
      modes = '{qni_pkg::MODE_NORMALIZE, qni_pkg::MODE_CONJUGATE,
                qni_pkg::MODE_INVERSE, qni_pkg::MODE_MAGNITUDE};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, unit, full-scale extremes and negation of the most negative value
      foreach (modes[i]) begin
         add_quat(modes[i], 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         add_quat(modes[i], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         add_quat(modes[i], 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
         add_quat(modes[i], 16'h0000, 16'h0000, 16'h0000, 16'h1000);
         add_quat(modes[i], 16'h8000, 16'h0000, 16'h0001, 16'hffff);
      end
      add_quat(qni_pkg::MODE_INVERSE, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
      add_quat(qni_pkg::MODE_NORMALIZE, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
      wait_idle();

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 62 : (phase == 3) ? 33 : 0;
         stall_pct     = (phase == 2) ? 62 : (phase == 3) ? 33 : 0;
         for (int n = 0; n < 285; n++)
            add_quat(2'($urandom_range(3)), random_component(), random_component(),
                     random_component(), random_component(), n == 140);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
